// ----- rtl/knb_pkg.sv -----
// Shared types, constants and helpers for the k-mer naive Bayes classifier.
`default_nettype none

package knb_pkg;

    // Default sizes of the block.
    localparam int KMER_LEN_DEF      = 8;
    localparam int MAX_GENERA_DEF    = 16;
    localparam int MAX_SEQ_LEN_DEF   = 4096;
    localparam int MIN_QUERY_LEN_DEF = 50;

    // Fixed field and counter widths.
    localparam int CFG_W   = 5;
    localparam int CNT_W   = 16;
    localparam int BASES_W = 13;
    localparam logic [CFG_W-1:0]   NUM_GENERA_RST = 5'd1;
    localparam logic [CNT_W-1:0]   CNT_MAX        = 16'hFFFF;
    localparam logic [BASES_W-1:0] BASES_MAX      = 13'h1FFF;

    // Fixed-point log2 unit: input width, fraction bits and result width.
    localparam int LOG_XW   = 34;
    localparam int LOG_FRAC = 16;
    localparam int LOG_RW   = 22;

    // ASCII nucleotide codes.
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BASE  = 2'd1,
        ST_SHORT     = 2'd2,
        ST_BAD_GENUS = 2'd3
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] base;
        logic [3:0] ref_genus;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic       done_kind;
        logic [3:0] best_genus;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TAGCLR,
        S_PROC,
        S_TRAIN_WR,
        S_FINISH,
        S_SC_GEN,
        S_SC_LIST,
        S_SC_KM,
        S_SC_X,
        S_SC_LOGW,
        S_SC_PEN,
        S_SC_PENW,
        S_SC_CMP,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_all;
        logic clr_tag;
        logic accept;
        logic proc;
        logic train_wr;
        logic finish;
        logic sc_gen;
        logic sc_km;
        logic sc_x;
        logic sc_acc;
        logic sc_pen;
        logic sc_pen_done;
        logic sc_cmp;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wrap;
        logic train;
        logic last;
        logic score_go;
        logic clr_end_all;
        logic clr_end_tag;
        logic list_empty;
        logic p_last;
        logic g_last;
        logic log_done;
        logic out_free;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kmer_naive_bayes_classifier_top.sv -----
// Top level of the k-mer naive Bayes genus classifier.
//
// Nucleotides arrive one request at a time on the input channel (valid/stall);
// a request is taken at a clock edge with i_in_valid high and o_in_stall low.
// Reference sequences train the count memories; query sequences are listed
// and scored per genus at their last base. Each base with last set produces
// one result request on the output channel; other bases produce none.
// Each base is taken in the idle state and handled in the per-base state; one
// that trains a k-mer adds a write step (read, then write of the tag and count
// memories through their write port); no new base is taken meanwhile. At a
// query's end, scoring runs the iterative log2 unit (16 squarings per term).
// Reset clears control state, then a sweep zeroes the count, total and tag
// memories, one entry per cycle over all MAX_GENERA * 4^KMER_LEN entries
// (1,048,576 by default); inputs are stalled meanwhile. After every 65535
// references, the next reference first sweeps all 4^KMER_LEN tag entries.
// A finished result waits in an output register as more bases are taken; the
// next result is held, input stalled, until the first is taken. The user must
// write num_genera via i_cfg_we/i_cfg_wdata while the block is idle; not enforced.
`default_nettype none

module kmer_naive_bayes_classifier_top #(
    parameter int KMER_LEN      = knb_pkg::KMER_LEN_DEF,
    parameter int MAX_GENERA    = knb_pkg::MAX_GENERA_DEF,
    parameter int MAX_SEQ_LEN   = knb_pkg::MAX_SEQ_LEN_DEF,
    parameter int MIN_QUERY_LEN = knb_pkg::MIN_QUERY_LEN_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire knb_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output knb_pkg::t_out_item             o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [knb_pkg::CFG_W-1:0] i_cfg_wdata
);

    knb_pkg::t_cmd  cmd;
    knb_pkg::t_stat stat;

    knb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_stat(stat), .o_in_stall(o_in_stall), .o_cmd(cmd)
    );

    knb_dp #(
        .KMER_LEN(KMER_LEN), .MAX_GENERA(MAX_GENERA),
        .MAX_SEQ_LEN(MAX_SEQ_LEN), .MIN_QUERY_LEN(MIN_QUERY_LEN)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_data(i_in_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .i_cmd(cmd), .o_stat(stat),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid), .o_out_data(o_out_data)
    );

    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten");

    // No base is taken while the memories are being cleared.
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.clr_all || cmd.clr_tag) |-> o_in_stall)
        else $error("input taken during clear sweep");

    // Per-base, training and scoring steps never overlap.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.proc, cmd.train_wr, cmd.finish, cmd.sc_acc, cmd.sc_cmp}))
        else $error("overlapping datapath steps");

    // A loaded result is presented on the next cycle.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- rtl/knb_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module knb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/knb_log2.sv -----
// Iterative fixed-point log2 unit: a normalize step, then one squaring per fraction bit.
`default_nettype none

module knb_log2 (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [knb_pkg::LOG_XW-1:0]   i_x,
    output logic                              o_done,
    output logic      [knb_pkg::LOG_RW-1:0]   o_result
);

    logic                          r_busy;
    logic                          r_norm;
    logic [4:0]                    r_cnt;
    logic [knb_pkg::LOG_XW-1:0]    r_x;
    logic [30:0]                   r_y;
    logic [knb_pkg::LOG_RW-1:0]    r_r;
    logic                          r_done;

    logic [5:0]                    exp_c;
    logic [knb_pkg::LOG_XW+29:0]   shifted;
    logic [61:0]                   square;
    logic [31:0]                   sq_hi;

    // Leading-one position and mantissa alignment to Q1.30.
    always_comb begin
        exp_c = 6'd0;
        for (int i = 0; i < knb_pkg::LOG_XW; i++) begin
            if (r_x[i]) begin
                exp_c = 6'(i);
            end
        end
        shifted = {r_x, 30'b0} >> exp_c;
        square  = {31'b0, r_y} * {31'b0, r_y};
        sq_hi   = square[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_norm <= 1'b0;
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_busy <= 1'b1;
                r_norm <= 1'b1;
            end else if (r_busy && r_norm) begin
                r_y    <= shifted[30:0];
                r_r    <= knb_pkg::LOG_RW'(exp_c);
                r_cnt  <= 5'(knb_pkg::LOG_FRAC);
                r_norm <= 1'b0;
            end else if (r_busy) begin
                // Square, then take one fraction bit from the overflow.
                r_r   <= {r_r[knb_pkg::LOG_RW-2:0], sq_hi[31]};
                r_y   <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

`default_nettype wire

// ----- rtl/knb_ctrl.sv -----
// Controller state machine that sequences training, query listing and scoring.
`default_nettype none

module knb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire knb_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output knb_pkg::t_cmd       o_cmd
);

    knb_pkg::t_state r_state;
    knb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            knb_pkg::S_CLEAR: begin
                if (i_stat.clr_end_all) n_state = knb_pkg::S_IDLE;
            end
            knb_pkg::S_IDLE: begin
                if (i_in_valid) n_state = i_stat.wrap ? knb_pkg::S_TAGCLR : knb_pkg::S_PROC;
            end
            knb_pkg::S_TAGCLR: begin
                if (i_stat.clr_end_tag) n_state = knb_pkg::S_PROC;
            end
            knb_pkg::S_PROC: begin
                if (i_stat.train)     n_state = knb_pkg::S_TRAIN_WR;
                else if (i_stat.last) n_state = knb_pkg::S_FINISH;
                else                  n_state = knb_pkg::S_IDLE;
            end
            knb_pkg::S_TRAIN_WR: n_state = knb_pkg::S_IDLE;
            knb_pkg::S_FINISH: begin
                n_state = i_stat.score_go ? knb_pkg::S_SC_GEN : knb_pkg::S_OUT;
            end
            knb_pkg::S_SC_GEN: begin
                n_state = i_stat.list_empty ? knb_pkg::S_SC_PEN : knb_pkg::S_SC_LIST;
            end
            knb_pkg::S_SC_LIST: n_state = knb_pkg::S_SC_KM;
            knb_pkg::S_SC_KM:   n_state = knb_pkg::S_SC_X;
            knb_pkg::S_SC_X:    n_state = knb_pkg::S_SC_LOGW;
            knb_pkg::S_SC_LOGW: begin
                if (i_stat.log_done) begin
                    n_state = i_stat.p_last ? knb_pkg::S_SC_PEN : knb_pkg::S_SC_LIST;
                end
            end
            knb_pkg::S_SC_PEN: n_state = knb_pkg::S_SC_PENW;
            knb_pkg::S_SC_PENW: begin
                if (i_stat.log_done) n_state = knb_pkg::S_SC_CMP;
            end
            knb_pkg::S_SC_CMP: begin
                n_state = i_stat.g_last ? knb_pkg::S_OUT : knb_pkg::S_SC_GEN;
            end
            knb_pkg::S_OUT: begin
                if (i_stat.out_free) n_state = knb_pkg::S_IDLE;
            end
            default: n_state = knb_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = (r_state != knb_pkg::S_IDLE);
        case (r_state)
            knb_pkg::S_CLEAR:    o_cmd.clr_all     = 1'b1;
            knb_pkg::S_IDLE:     o_cmd.accept      = i_in_valid;
            knb_pkg::S_TAGCLR:   o_cmd.clr_tag     = 1'b1;
            knb_pkg::S_PROC:     o_cmd.proc        = 1'b1;
            knb_pkg::S_TRAIN_WR: o_cmd.train_wr    = 1'b1;
            knb_pkg::S_FINISH:   o_cmd.finish      = 1'b1;
            knb_pkg::S_SC_GEN:   o_cmd.sc_gen      = 1'b1;
            knb_pkg::S_SC_KM:    o_cmd.sc_km       = 1'b1;
            knb_pkg::S_SC_X:     o_cmd.sc_x        = 1'b1;
            knb_pkg::S_SC_LOGW:  o_cmd.sc_acc      = i_stat.log_done;
            knb_pkg::S_SC_PEN:   o_cmd.sc_pen      = 1'b1;
            knb_pkg::S_SC_PENW:  o_cmd.sc_pen_done = i_stat.log_done;
            knb_pkg::S_SC_CMP:   o_cmd.sc_cmp      = 1'b1;
            knb_pkg::S_OUT:      o_cmd.out_load    = i_stat.out_free;
            default:             o_cmd             = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/knb_dp.sv -----
// Datapath: sequence state, count memories, query list, scoring and result register.
`default_nettype none

module knb_dp #(
    parameter int KMER_LEN      = knb_pkg::KMER_LEN_DEF,
    parameter int MAX_GENERA    = knb_pkg::MAX_GENERA_DEF,
    parameter int MAX_SEQ_LEN   = knb_pkg::MAX_SEQ_LEN_DEF,
    parameter int MIN_QUERY_LEN = knb_pkg::MIN_QUERY_LEN_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire knb_pkg::t_in_item         i_in_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [knb_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire knb_pkg::t_cmd             i_cmd,
    output knb_pkg::t_stat                 o_stat,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output knb_pkg::t_out_item             o_out_data
);

    localparam int KW     = 2 * KMER_LEN;
    localparam int NKMERS = 1 << KW;
    localparam int GIW    = (MAX_GENERA > 1) ? $clog2(MAX_GENERA) : 1;
    localparam int CDEPTH = MAX_GENERA * NKMERS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int AW     = $clog2(MAX_SEQ_LEN);
    localparam int LW     = $clog2(MAX_SEQ_LEN + 1);
    localparam int NG_CAP = (MAX_GENERA > 31) ? 31 : MAX_GENERA;
    localparam int SUMW   = LW + knb_pkg::LOG_RW;
    localparam int SW     = SUMW + 1;
    localparam int CW     = knb_pkg::CNT_W;

    // Sequence state.
    logic [knb_pkg::CFG_W-1:0]   r_num_genera;
    logic [knb_pkg::BASES_W-1:0] r_bases;
    knb_pkg::t_status            r_err;
    logic [KW-1:0]               r_window;
    logic [LW-1:0]               r_listed;
    logic                        r_cur_kind;
    logic [GIW-1:0]              r_cur_genus;
    logic [CW-1:0]               r_serial;
    logic [1:0]                  r_code;
    logic                        r_code_ok;
    logic                        r_last;
    logic [KW-1:0]               r_kmer;
    logic [CAW-1:0]              r_clr;
    logic [CW-1:0]               r_grc [MAX_GENERA];
    logic [CW-1:0]               r_ref_total;

    // Scoring state and result.
    logic [knb_pkg::CFG_W-1:0]   r_g;
    logic [LW-1:0]               r_p;
    logic [SUMW-1:0]             r_sum;
    logic [SUMW-1:0]             r_pen;
    logic signed [SW-1:0]        r_best_score;
    logic [knb_pkg::CFG_W-1:0]   r_best;
    knb_pkg::t_status            r_res_status;
    logic                        r_out_valid;
    knb_pkg::t_out_item          r_out;

    logic [knb_pkg::CFG_W-1:0]   ng;
    logic [1:0]                  code_c;
    logic                        code_ok_c;
    knb_pkg::t_status            err_n;
    logic [KW-1:0]               kmer_n;
    logic                        do_kmer;
    logic                        list_we;
    knb_pkg::t_status            fin_status;
    logic signed [SW-1:0]        score;
    logic [32:0]                 prod;
    logic [knb_pkg::LOG_XW-1:0]  x_kmer;
    logic [knb_pkg::LOG_XW-1:0]  x_log;
    logic                        log_done;
    logic [knb_pkg::LOG_RW-1:0]  log_r;
    logic                        upd;
    logic                        clr_end;

    // Memory ports.
    logic           cnt_we,  tot_we,  tag_we;
    logic [CAW-1:0] cnt_waddr, cnt_raddr;
    logic [KW-1:0]  tot_waddr, tot_raddr, tag_waddr;
    logic [CW-1:0]  cnt_wdata, tot_wdata, tag_wdata;
    logic [CW-1:0]  cnt_rdata, tot_rdata, tag_rdata;
    logic [KW-1:0]  list_rdata;
    logic [KW-1:0]  list_kmer;

    assign ng = (r_num_genera > knb_pkg::CFG_W'(NG_CAP)) ?
                knb_pkg::CFG_W'(NG_CAP) : r_num_genera;

    // Nucleotide decode.
    always_comb begin
        code_ok_c = 1'b1;
        case (i_in_data.base)
            knb_pkg::CHAR_A: code_c = 2'd0;
            knb_pkg::CHAR_C: code_c = 2'd1;
            knb_pkg::CHAR_G: code_c = 2'd2;
            knb_pkg::CHAR_T: code_c = 2'd3;
            default: begin
                code_c    = 2'd0;
                code_ok_c = 1'b0;
            end
        endcase
    end

    // Per-base decisions for the accepted base.
    always_comb begin
        err_n   = (r_err == knb_pkg::ST_OK && !r_code_ok) ? knb_pkg::ST_BAD_BASE : r_err;
        kmer_n  = KW'({r_window, r_code});
        do_kmer = (err_n == knb_pkg::ST_OK) && !r_last &&
                  (r_bases >= knb_pkg::BASES_W'(KMER_LEN - 1));
        list_we = i_cmd.proc && do_kmer && r_cur_kind &&
                  (r_listed < LW'(MAX_SEQ_LEN));
    end

    // Status at the end of a sequence.
    always_comb begin
        if (r_err != knb_pkg::ST_OK) begin
            fin_status = r_err;
        end else if (r_cur_kind && r_bases < knb_pkg::BASES_W'(MIN_QUERY_LEN)) begin
            fin_status = knb_pkg::ST_SHORT;
        end else if (r_cur_kind && ng == '0) begin
            fin_status = knb_pkg::ST_BAD_GENUS;
        end else begin
            fin_status = knb_pkg::ST_OK;
        end
    end

    // Log argument for one k-mer: 2*cnt*(1+refs) + 2*tot + 1.
    always_comb begin
        prod   = {17'b0, cnt_rdata} * {16'b0, 17'({1'b0, r_ref_total} + 17'd1)};
        x_kmer = {prod, 1'b0} + knb_pkg::LOG_XW'({tot_rdata, 1'b1});
        x_log  = i_cmd.sc_pen ? (knb_pkg::LOG_XW'(r_grc[GIW'(r_g)]) + 1'b1) : x_kmer;
        score  = $signed({1'b0, r_sum}) - $signed({1'b0, r_pen});
    end

    assign upd     = (tag_rdata != r_serial);
    assign clr_end = i_cmd.clr_all ? (r_clr == CAW'(CDEPTH - 1)) : (r_clr[KW-1:0] == '1);
    assign list_kmer = list_rdata;

    // Memory address and write selection.
    always_comb begin
        cnt_raddr = i_cmd.sc_km ? CAW'({GIW'(r_g), list_kmer}) : CAW'({r_cur_genus, kmer_n});
        tot_raddr = i_cmd.sc_km ? list_kmer : kmer_n;
        cnt_we    = i_cmd.clr_all || (i_cmd.train_wr && upd);
        tot_we    = cnt_we;
        tag_we    = i_cmd.clr_all || i_cmd.clr_tag || (i_cmd.train_wr && upd);
        cnt_waddr = i_cmd.clr_all ? r_clr : CAW'({r_cur_genus, r_kmer});
        tot_waddr = i_cmd.clr_all ? r_clr[KW-1:0] : r_kmer;
        tag_waddr = (i_cmd.clr_all || i_cmd.clr_tag) ? r_clr[KW-1:0] : r_kmer;
        cnt_wdata = i_cmd.clr_all ? '0 : knb_pkg::sat_inc16(cnt_rdata);
        tot_wdata = i_cmd.clr_all ? '0 : knb_pkg::sat_inc16(tot_rdata);
        tag_wdata = (i_cmd.clr_all || i_cmd.clr_tag) ? '0 : r_serial;
    end

    knb_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_counts (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rdata)
    );

    knb_ram #(.WIDTH(CW), .DEPTH(NKMERS)) u_totals (
        .i_clk(i_clk), .i_we(tot_we), .i_waddr(tot_waddr), .i_wdata(tot_wdata),
        .i_raddr(tot_raddr), .o_rdata(tot_rdata)
    );

    knb_ram #(.WIDTH(CW), .DEPTH(NKMERS)) u_tags (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(kmer_n), .o_rdata(tag_rdata)
    );

    knb_ram #(.WIDTH(KW), .DEPTH(MAX_SEQ_LEN)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(r_listed[AW-1:0]), .i_wdata(kmer_n),
        .i_raddr(r_p[AW-1:0]), .o_rdata(list_rdata)
    );

    knb_log2 u_log2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.sc_x || i_cmd.sc_pen),
        .i_x(x_log), .o_done(log_done), .o_result(log_r)
    );

    // Sequence and training state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_genera <= knb_pkg::NUM_GENERA_RST;
            r_bases      <= '0;
            r_err        <= knb_pkg::ST_OK;
            r_window     <= '0;
            r_listed     <= '0;
            r_cur_kind   <= 1'b0;
            r_cur_genus  <= '0;
            r_serial     <= '0;
            r_clr        <= '0;
            r_ref_total  <= '0;
            for (int i = 0; i < MAX_GENERA; i++) begin
                r_grc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_num_genera <= i_cfg_wdata;
            end
            if (i_cmd.clr_all || i_cmd.clr_tag) begin
                r_clr <= clr_end ? '0 : r_clr + 1'b1;
            end
            // A new sequence starts on its first base.
            if (i_cmd.accept && r_bases == '0) begin
                r_cur_kind  <= i_in_data.kind;
                r_cur_genus <= GIW'(i_in_data.ref_genus);
                r_window    <= '0;
                r_listed    <= '0;
                r_err       <= (!i_in_data.kind &&
                                {1'b0, i_in_data.ref_genus} >= ng) ?
                               knb_pkg::ST_BAD_GENUS : knb_pkg::ST_OK;
                if (!i_in_data.kind) begin
                    r_serial <= (r_serial == knb_pkg::CNT_MAX) ? CW'(1) : r_serial + 1'b1;
                end
            end
            if (i_cmd.proc) begin
                r_err <= err_n;
                if (err_n == knb_pkg::ST_OK) begin
                    r_window <= kmer_n;
                end
                r_kmer <= kmer_n;
                if (list_we) begin
                    r_listed <= r_listed + 1'b1;
                end
                if (r_bases != knb_pkg::BASES_MAX) begin
                    r_bases <= r_bases + 1'b1;
                end
            end
            // A clean reference counts toward the genus priors.
            if (i_cmd.finish) begin
                if (!r_cur_kind && r_err == knb_pkg::ST_OK) begin
                    r_grc[r_cur_genus] <= knb_pkg::sat_inc16(r_grc[r_cur_genus]);
                    r_ref_total        <= knb_pkg::sat_inc16(r_ref_total);
                end
                r_bases  <= '0;
                r_err    <= knb_pkg::ST_OK;
                r_window <= '0;
            end
        end
    end

    // Accepted base fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_code    <= code_c;
            r_code_ok <= code_ok_c;
            r_last    <= i_in_data.last;
        end
    end

    // Scoring accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g          <= '0;
            r_p          <= '0;
            r_best       <= '0;
            r_res_status <= knb_pkg::ST_OK;
        end else begin
            if (i_cmd.finish) begin
                r_res_status <= fin_status;
                r_g          <= '0;
                r_best       <= '0;
            end
            if (i_cmd.sc_gen) begin
                r_sum <= '0;
                r_p   <= '0;
            end
            if (i_cmd.sc_acc) begin
                r_sum <= r_sum + SUMW'(log_r);
                r_p   <= r_p + 1'b1;
            end
            if (i_cmd.sc_pen_done) begin
                r_pen <= SUMW'(r_listed) * SUMW'(log_r);
            end
            // Strictly larger score wins; the first genus always loads.
            if (i_cmd.sc_cmp) begin
                if (r_g == '0 || score > r_best_score) begin
                    r_best_score <= score;
                    r_best       <= r_g;
                end
                r_g <= r_g + 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.done_kind  <= r_cur_kind;
            r_out.best_genus <= (r_cur_kind && r_res_status == knb_pkg::ST_OK) ?
                                r_best[3:0] : 4'd0;
            r_out.status     <= r_res_status;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.wrap        = (r_bases == '0) && !i_in_data.kind && (r_serial == knb_pkg::CNT_MAX);
        o_stat.train       = do_kmer && !r_cur_kind;
        o_stat.last        = r_last;
        o_stat.score_go    = r_cur_kind && (fin_status == knb_pkg::ST_OK);
        o_stat.clr_end_all = i_cmd.clr_all && clr_end;
        o_stat.clr_end_tag = i_cmd.clr_tag && clr_end;
        o_stat.list_empty  = (r_listed == '0);
        o_stat.p_last      = ({1'b0, r_p} + 1'b1) == {1'b0, r_listed};
        o_stat.g_last      = ({1'b0, r_g} + 1'b1) == {1'b0, ng};
        o_stat.log_done    = log_done;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- bench/kmer_naive_bayes_classifier_top_test.sv -----
// Self-checking testbench for the k-mer naive Bayes genus classifier.
`default_nettype none

module kmer_naive_bayes_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_REF   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam int   NKM        = 1 << (2 * knb_pkg::KMER_LEN_DEF);
    localparam int   NGEN       = knb_pkg::MAX_GENERA_DEF;
    localparam int   TMPL_LEN   = 64;
    localparam int   HOLD_CYC   = 2000;
    localparam logic [7:0] NT_A = knb_pkg::CHAR_A;
    localparam logic [7:0] NT_C = knb_pkg::CHAR_C;
    localparam logic [7:0] NT_G = knb_pkg::CHAR_G;
    localparam logic [7:0] NT_T = knb_pkg::CHAR_T;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    knb_pkg::t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    knb_pkg::t_out_item  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [knb_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    kmer_naive_bayes_classifier_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Classifier state mirrored by the predictor.
    bit [15:0]  mdl_counts [NGEN*NKM];
    bit [15:0]  mdl_totals [NKM];
    bit [15:0]  mdl_tag    [NKM];
    bit [15:0]  mdl_refs   [NGEN];
    bit [15:0]  mdl_ref_total = '0;
    bit [15:0]  mdl_window = '0;
    bit [12:0]  mdl_seen = '0;
    bit [1:0]   mdl_err = '0;
    bit [15:0]  mdl_list [$];
    bit [4:0]   mdl_genera = knb_pkg::NUM_GENERA_RST;
    bit         mdl_kind = '0;
    bit [3:0]   mdl_genus = '0;
    bit [15:0]  mdl_serial = '0;

    knb_pkg::t_out_item  expected_results [$];
    int         mismatches = 0;
    int         accepted_bases = 0;
    bit         calm = 1'b0;
    bit         hold_go = 1'b0;
    bit         hold = 1'b0;
    bit [1:0]   tmpl [NGEN][TMPL_LEN];

    // Directed stimulus: typed rows carry the result read off directly.
    typedef struct {
        logic       kind;
        logic [7:0] base;
        logic [3:0] genus;
        logic       last;
        bit         typed;
        knb_pkg::t_out_item  res;
    } t_row;

    t_row directed [] = '{
        '{KIND_REF,   NT_A,  4'd3,  1'b1, 1'b1, '{KIND_REF, 4'd0, knb_pkg::ST_BAD_GENUS}},
        '{KIND_REF,   8'h58, 4'd0,  1'b1, 1'b1, '{KIND_REF, 4'd0, knb_pkg::ST_BAD_BASE}},
        '{KIND_REF,   8'h00, 4'd0,  1'b1, 1'b1, '{KIND_REF, 4'd0, knb_pkg::ST_BAD_BASE}},
        '{KIND_REF,   8'hFF, 4'd15, 1'b1, 1'b1, '{KIND_REF, 4'd0, knb_pkg::ST_BAD_GENUS}},
        '{KIND_QUERY, NT_G,  4'd0,  1'b1, 1'b1, '{KIND_QUERY, 4'd0, knb_pkg::ST_SHORT}},
        '{KIND_QUERY, 8'hFF, 4'd0,  1'b1, 1'b1, '{KIND_QUERY, 4'd0, knb_pkg::ST_BAD_BASE}},
        '{KIND_REF,   NT_A,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_QUERY, NT_C,  4'd15, 1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_QUERY, NT_G,  4'd15, 1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_T,  4'd7,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_A,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_C,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_G,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_T,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_A,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_C,  4'd0,  1'b1, 1'b1, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_A,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_C,  4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   8'h4E, 4'd0,  1'b0, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}},
        '{KIND_REF,   NT_T,  4'd0,  1'b1, 1'b0, '{KIND_REF, 4'd0, knb_pkg::ST_OK}}
    };

    // Fixed-point log2 with 16 fraction bits, found by repeated squaring.
    function automatic longint unsigned log2_q16(longint unsigned x);
        int unsigned e;
        longint unsigned t, y, r;
        e = 0;
        t = x;
        if (x == 0) return 0;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        y = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        r = e;
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= 64'h8000_0000) begin
                r = r | 1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic bit [15:0] sat_up(bit [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Advance the classifier by one accepted base; returns 1 with a result on a last base.
    function automatic bit classify_base(knb_pkg::t_in_item it, output knb_pkg::t_out_item res);
        int         code;
        int         ng;
        bit [15:0]  kmer;
        bit [1:0]   st;
        int         best;
        longint     best_score, score;
        longint unsigned refs1;
        int         idx;
        ng = (mdl_genera > NGEN) ? NGEN : mdl_genera;
        best = 0;
        case (it.base)
            NT_A: code = 0;
            NT_C: code = 1;
            NT_G: code = 2;
            NT_T: code = 3;
            default: code = -1;
        endcase
        if (mdl_seen == 0) begin
            mdl_kind = it.kind;
            mdl_genus = it.ref_genus;
            mdl_err = knb_pkg::ST_OK;
            mdl_window = '0;
            mdl_list.delete();
            if (it.kind == KIND_REF) begin
                if (mdl_serial == 16'hFFFF) begin
                    foreach (mdl_tag[i]) mdl_tag[i] = '0;
                    mdl_serial = 16'd1;
                end else begin
                    mdl_serial++;
                end
                if (it.ref_genus >= ng) mdl_err = knb_pkg::ST_BAD_GENUS;
            end
        end
        if (code < 0 && mdl_err == knb_pkg::ST_OK) mdl_err = knb_pkg::ST_BAD_BASE;
        if (mdl_err == knb_pkg::ST_OK) begin
            kmer = {mdl_window[13:0], code[1:0]};
            mdl_window = kmer;
            if (!it.last && int'(mdl_seen) + 1 >= knb_pkg::KMER_LEN_DEF) begin
                if (mdl_kind == KIND_REF) begin
                    if (mdl_tag[kmer] != mdl_serial) begin
                        idx = int'(mdl_genus) * NKM + int'(kmer);
                        mdl_tag[kmer] = mdl_serial;
                        mdl_totals[kmer] = sat_up(mdl_totals[kmer]);
                        mdl_counts[idx] = sat_up(mdl_counts[idx]);
                    end
                end else if (mdl_list.size() < knb_pkg::MAX_SEQ_LEN_DEF) begin
                    mdl_list = {mdl_list, kmer};
                end
            end
        end
        if (mdl_seen != knb_pkg::BASES_MAX) mdl_seen++;
        if (!it.last) return 1'b0;

        st = mdl_err;
        if (mdl_kind == KIND_REF) begin
            if (st == knb_pkg::ST_OK) begin
                mdl_refs[mdl_genus] = sat_up(mdl_refs[mdl_genus]);
                mdl_ref_total = sat_up(mdl_ref_total);
            end
        end else if (st == knb_pkg::ST_OK) begin
            if (mdl_seen < knb_pkg::MIN_QUERY_LEN_DEF) begin
                st = knb_pkg::ST_SHORT;
            end else if (ng == 0) begin
                st = knb_pkg::ST_BAD_GENUS;
            end else begin
                refs1 = 1 + longint'(mdl_ref_total);
                best_score = 0;
                // Score every genus in use; the strict maximum wins.
                for (int g = 0; g < ng; g++) begin
                    score = 0;
                    foreach (mdl_list[p]) begin
                        score += longint'(log2_q16(
                            2 * longint'(mdl_counts[g*NKM + int'(mdl_list[p])]) * refs1
                            + 2 * longint'(mdl_totals[mdl_list[p]]) + 1));
                    end
                    score -= longint'(mdl_list.size()) *
                             longint'(log2_q16(1 + longint'(mdl_refs[g])));
                    if (g == 0 || score > best_score) begin
                        best_score = score;
                        best = g;
                    end
                end
            end
        end
        res.done_kind = mdl_kind;
        res.best_genus = (st == knb_pkg::ST_OK && mdl_kind == KIND_QUERY) ? best[3:0] : 4'd0;
        res.status = st;
        mdl_seen = '0;
        mdl_err = knb_pkg::ST_OK;
        mdl_window = '0;
        mdl_list.delete();
        return 1'b1;
    endfunction

    // Offer one base request and wait for it to be taken.
    task automatic send_base(knb_pkg::t_in_item it, bit typed = 1'b0,
                             knb_pkg::t_out_item typed_res = '0);
        knb_pkg::t_out_item res;
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        if (classify_base(it, res)) begin
            expected_results = {expected_results, typed ? typed_res : res};
        end
        accepted_bases++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] nucleotide(bit [1:0] c);
        case (c)
            2'd0: return NT_A;
            2'd1: return NT_C;
            2'd2: return NT_G;
            default: return NT_T;
        endcase
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == NT_A || b == NT_C || b == NT_G || b == NT_T);
        return b;
    endfunction

    // Send one sequence drawn from a genus template, with rare mutations and
    // an optional bad base; fields after the first base are randomized.
    task automatic send_sequence(logic kind, int genus, int len, int bad_pos);
        int start;
        knb_pkg::t_in_item it;
        start = $urandom_range(TMPL_LEN - 1);
        for (int i = 0; i < len; i++) begin
            it.base = ($urandom_range(99) < 3) ? nucleotide(2'($urandom))
                      : nucleotide(tmpl[genus % NGEN][(start + i) % TMPL_LEN]);
            if (i == bad_pos) it.base = junk_byte();
            it.kind = (i == 0) ? kind : 1'($urandom);
            it.ref_genus = (i == 0) ? 4'(genus) : 4'($urandom);
            it.last = (i == len - 1);
            send_base(it);
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_genera(logic [knb_pkg::CFG_W-1:0] v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mdl_genera = v;
    endtask

    // Random sequences until the base budget of the phase is used up.
    task automatic random_phase(int budget, bit with_pressure);
        int stop_at, r, len;
        stop_at = accepted_bases + budget;
        while (accepted_bases < stop_at) begin
            if (with_pressure && accepted_bases + budget / 2 >= stop_at && !hold_go) begin
                hold_go = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 62) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 25);
                send_sequence(KIND_REF, $urandom_range(15), len,
                              ($urandom_range(99) < 6) ? $urandom_range(len - 1) : -1);
            end else if (r < 82) begin
                len = $urandom_range(knb_pkg::MIN_QUERY_LEN_DEF,
                                     knb_pkg::MIN_QUERY_LEN_DEF + 12);
                send_sequence(KIND_QUERY, $urandom_range(15), len,
                              ($urandom_range(99) < 8) ? $urandom_range(len - 1) : -1);
            end else if (r < 90) begin
                send_sequence(KIND_QUERY, $urandom_range(15),
                              $urandom_range(1, knb_pkg::MIN_QUERY_LEN_DEF - 1), -1);
            end else begin
                // Noise: a short sequence of either kind with one random non-nucleotide byte.
                len = $urandom_range(1, 10);
                send_sequence(1'($urandom), $urandom_range(15), len, $urandom_range(len - 1));
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off timed by the block below.
    always @(negedge i_clk) begin
        i_out_stall <= hold || (!calm && $urandom_range(99) < 38);
    end

    initial begin
        wait (hold_go);
        @(negedge i_clk);
        hold = 1'b1;
        for (int n = 0; n < HOLD_CYC; n++) @(negedge i_clk);
        hold = 1'b0;
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        knb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.done_kind !== want.done_kind
                    || o_out_data.best_genus !== want.best_genus
                    || o_out_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected kind %0d genus %0d status %0d,",
                                 want.done_kind, want.best_genus, want.status,
                                 " got kind %0d genus %0d status %0d",
                                 o_out_data.done_kind, o_out_data.best_genus,
                                 o_out_data.status);
                    end
                end
            end
        end
    end

    initial begin
        #80ms;
        $display("kmer_naive_bayes_classifier_top_test NOT OK");
        $finish;
    end

    // Main sequence: reset, directed rows, a trained genus and its query, random phases.
    initial begin
        knb_pkg::t_in_item it;
        foreach (tmpl[g, i]) tmpl[g][i] = 2'($urandom);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            it.kind = directed[i].kind;
            it.base = directed[i].base;
            it.ref_genus = directed[i].genus;
            it.last = directed[i].last;
            send_base(it, directed[i].typed, directed[i].res);
        end

        // One reference of genus 0, then a query drawn from the same template.
        send_sequence(KIND_REF, 0, 30, -1);
        send_sequence(KIND_QUERY, 0, 64, -1);

        write_genera(5'd16);
        random_phase(300, 1'b1);
        wait_drained();
        calm = 1'b1;
        random_phase(250, 1'b0);
        calm = 1'b0;
        write_genera(5'd0);
        send_sequence(KIND_QUERY, 2, 55, -1);
        random_phase(80, 1'b0);
        write_genera(5'd31);
        random_phase(200, 1'b0);
        write_genera(5'd5);
        random_phase(200, 1'b0);
        write_genera(5'd1);
        random_phase(120, 1'b0);

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("kmer_naive_bayes_classifier_top_test OK");
        end else begin
            $display("kmer_naive_bayes_classifier_top_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/knb_pkg.sv
rtl/knb_ram.sv
rtl/knb_log2.sv
rtl/knb_ctrl.sv
rtl/knb_dp.sv
rtl/kmer_naive_bayes_classifier_top.sv
bench/kmer_naive_bayes_classifier_top_test.sv
